/* rtl/core/pftp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pftp_pkg
// shared constants and types of the pid filter table programmer
// ---------------------------------------------------------------------------
package pftp_pkg;

  localparam int SLOTS_DEF = 8;

  localparam int PID_W   = 16;
  localparam int WORD_W  = 16;
  localparam int SLOT_W  = 3;
  localparam int ENTRY_W = 6;

  localparam logic [7:0]        TYPE_TABLE    = 8'h81;
  localparam logic [7:0]        TYPE_CTRL     = 8'h82;
  localparam logic [WORD_W-1:0] CTRL_WORD     = 16'h02f5;
  localparam logic [PID_W-1:0]  FORCE_OFF_PID = 16'd8192;
  localparam logic [WORD_W-1:0] PID_FLAG      = 16'h8000;

  // one write command from the sequencer to the word unit
  typedef struct packed {
    logic               valid;
    logic               err;
    logic               ctrl;
    logic [ENTRY_W-1:0] entry;
    logic [PID_W-1:0]   pid;
    logic               half;
    logic               last;
  } seq_cmd_t;

  // one finished result item
  typedef struct packed {
    logic [WORD_W-1:0] write_value;
    logic [WORD_W-1:0] write_index;
    logic              status;
    logic              last;
  } out_word_t;

endpackage

/* rtl/core/pftp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pftp_in_if / pftp_out_if
// valid/ready channels of the pid filter table programmer
// ---------------------------------------------------------------------------
interface pftp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [pftp_pkg::SLOT_W-1:0] slot;
  logic [pftp_pkg::PID_W-1:0]  pid;
  logic                        on;

  modport source (output valid, mode, slot, pid, on, input ready);
  modport sink   (input valid, mode, slot, pid, on, output ready);
endinterface

interface pftp_out_if;
  logic                         valid;
  logic                         ready;
  logic [pftp_pkg::WORD_W-1:0]  write_value;
  logic [pftp_pkg::WORD_W-1:0]  write_index;
  logic                         status;
  logic                         last;

  modport source (output valid, write_value, write_index, status, last, input ready);
  modport sink   (input valid, write_value, write_index, status, last, output ready);
endinterface
`default_nettype wire

/* rtl/core/pftp_word_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pftp_word_unit
// shared value/index former used by every write of the sequence
// ---------------------------------------------------------------------------
module pftp_word_unit (
  input  pftp_pkg::seq_cmd_t  cmd,
  output pftp_pkg::out_word_t word
);

  always_comb begin
    word.status = cmd.err;
    word.last   = cmd.last;
    if (cmd.err) begin
      word.write_value = '0;
      word.write_index = '0;
    end else begin
      // second item of a pair carries a zero value
      word.write_value = cmd.half ? '0 : (cmd.pid | pftp_pkg::PID_FLAG);
      // type * 256 + entry * 4, entry * 4 stays below 256
      word.write_index = {(cmd.ctrl ? pftp_pkg::TYPE_CTRL : pftp_pkg::TYPE_TABLE),
                          cmd.entry, 2'b00};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pftp_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pftp_seq
// slot store, enable scan and write sequencer
// ---------------------------------------------------------------------------
module pftp_seq #(
  parameter int SLOTS = pftp_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic                        in_mode,
  input  logic [pftp_pkg::SLOT_W-1:0] in_slot,
  input  logic [pftp_pkg::PID_W-1:0]  in_pid,
  input  logic                        in_on,
  input  logic                        adv,
  output logic                        busy,
  output pftp_pkg::seq_cmd_t          cmd
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_HDR  = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_CTL0 = 3'd4;
  localparam logic [2:0] ST_PACK = 3'd5;
  localparam logic [2:0] ST_END  = 3'd6;

  logic [pftp_pkg::PID_W-1:0] slots_r [SLOTS];
  logic                       flag_r;

  logic [2:0]                   state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [pftp_pkg::ENTRY_W-1:0] entry_r, entry_nxt;
  logic                         half_r, half_nxt;
  logic                         en_r, en_nxt;

  logic [pftp_pkg::PID_W-1:0] cur_v;
  logic                       last_slot;

  assign cur_v     = slots_r[cnt_r[IDX_W-1:0]];
  assign last_slot = (cnt_r == CNT_W'(SLOTS - 1));
  assign busy      = (state_r != ST_IDLE);

  // slot store and filtering flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) slots_r[k] <= '0;
      flag_r <= 1'b0;
    end else if (acc) begin
      if (in_mode) begin
        flag_r <= in_on;
      end else begin
        for (int k = 0; k < SLOTS; k++) begin
          if (32'(in_slot) == k) slots_r[k] <= in_on ? in_pid : '0;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    entry_nxt = entry_r;
    half_nxt  = half_r;
    en_nxt    = en_r;

    cmd.valid = 1'b0;
    cmd.err   = 1'b0;
    cmd.ctrl  = 1'b0;
    cmd.entry = '0;
    cmd.pid   = '0;
    cmd.half  = half_r;
    cmd.last  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          en_nxt    = in_mode ? in_on : flag_r;
          cnt_nxt   = '0;
          half_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cur_v == pftp_pkg::FORCE_OFF_PID) en_nxt = 1'b0;
        if (last_slot) begin
          state_nxt = ST_HDR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_HDR: begin
        cmd.valid = 1'b1;
        cmd.entry = pftp_pkg::ENTRY_W'(1);
        cmd.pid   = pftp_pkg::PID_W'(en_r);
        if (adv) begin
          half_nxt = !half_r;
          if (half_r) begin
            cnt_nxt   = '0;
            state_nxt = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        cmd.valid = 1'b1;
        cmd.entry = pftp_pkg::ENTRY_W'(cnt_r) + pftp_pkg::ENTRY_W'(2);
        if (adv) begin
          half_nxt = !half_r;
          if (half_r) begin
            if (last_slot) begin
              state_nxt = ST_CTL0;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      ST_CTL0: begin
        cmd.valid = 1'b1;
        cmd.ctrl  = 1'b1;
        if (adv) begin
          half_nxt = !half_r;
          if (half_r) begin
            cnt_nxt   = '0;
            entry_nxt = pftp_pkg::ENTRY_W'(2);
            state_nxt = en_r ? ST_PACK : ST_END;
          end
        end
      end
      ST_PACK: begin
        if (cur_v == '0) begin
          // empty slot: no write, move on
          if (last_slot) begin
            state_nxt = ST_END;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else if (cur_v[pftp_pkg::PID_W-1]) begin
          // pid too large: one error item ends the run
          cmd.valid = 1'b1;
          cmd.err   = 1'b1;
          cmd.last  = 1'b1;
          if (adv) state_nxt = ST_IDLE;
        end else begin
          cmd.valid = 1'b1;
          cmd.entry = entry_r;
          cmd.pid   = cur_v;
          if (adv) begin
            half_nxt = !half_r;
            if (half_r) begin
              entry_nxt = entry_r + 1'b1;
              if (last_slot) begin
                state_nxt = ST_END;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
          end
        end
      end
      ST_END: begin
        cmd.valid = 1'b1;
        cmd.ctrl  = 1'b1;
        cmd.pid   = pftp_pkg::CTRL_WORD;
        cmd.last  = half_r;
        if (adv) begin
          half_nxt = !half_r;
          if (half_r) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      entry_r <= '0;
      half_r  <= 1'b0;
      en_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      entry_r <= entry_nxt;
      half_r  <= half_nxt;
      en_r    <= en_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pid_filter_table_programmer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pid_filter_table_programmer_core
// keeps the pid filter slots and emits the full table programming sequence
// ---------------------------------------------------------------------------
//
// channel   dir  fields                                       handshake
// in_ch     in   mode, slot, pid, on                          valid/ready
// out_ch    out  write_value, write_index, status, last       valid/ready
//
// one item: the sequencer accepts it, scans every slot for the force-off pid,
// then emits at most 4*SLOTS+6 write items, one per cycle while out_ch does
// not stall; empty slots are skipped while packing and emit no write
// in_ch.ready is high only while the sequencer is idle
// out_ch is a registered stage; a stall there holds the sequencer
// reset (synchronous, active low) clears all slots and the filtering flag
// ---------------------------------------------------------------------------
module pid_filter_table_programmer_core #(
  parameter int SLOTS = pftp_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pftp_in_if.sink           in_ch,
  pftp_out_if.source        out_ch
);

  logic                acc;
  logic                adv;
  logic                busy;
  logic                out_free;
  logic                out_valid_r;
  pftp_pkg::seq_cmd_t  cmd;
  pftp_pkg::out_word_t word;
  pftp_pkg::out_word_t word_r;

  // input item accepted only while idle
  assign in_ch.ready = !busy;
  assign acc         = in_ch.valid && in_ch.ready;

  // output stage can take a new item when empty or being drained
  assign out_free = !out_valid_r || out_ch.ready;
  assign adv      = cmd.valid && out_free;

  // sequencer owns the slot store and walks the write sequence
  pftp_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_mode (in_ch.mode),
    .in_slot (in_ch.slot),
    .in_pid  (in_ch.pid),
    .in_on   (in_ch.on),
    .adv     (adv),
    .busy    (busy),
    .cmd     (cmd)
  );

  // forms value and index words for every write
  pftp_word_unit u_word (
    .cmd  (cmd),
    .word (word)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= cmd.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (adv) word_r <= word;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.write_value = word_r.write_value;
  assign out_ch.write_index = word_r.write_index;
  assign out_ch.status      = word_r.status;
  assign out_ch.last        = word_r.last;

  // an error item is always the final one and carries no write
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |->
      out_ch.last && out_ch.write_value == '0 && out_ch.write_index == '0)
    else $error("error item malformed");

  // a valid write always addresses the table or the control register
  a_idx_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.status |->
      out_ch.write_index[15:8] == pftp_pkg::TYPE_TABLE ||
      out_ch.write_index[15:8] == pftp_pkg::TYPE_CTRL)
    else $error("write index of unknown type");

  // the block is busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ch.ready)
    else $error("item accepted while busy");

  // the final item of a valid run is the zero word after the control word
  a_last_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last && !out_ch.status |->
      out_ch.write_value == '0 &&
      out_ch.write_index[15:8] == pftp_pkg::TYPE_CTRL)
    else $error("run does not end with the control word");

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives filter updates into the pid filter table programmer, predicts the
// full write sequence of each update and checks every write item in order
// ---------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD     = 8;
  localparam int N_SLOTS        = pftp_pkg::SLOTS_DEF;
  localparam int FULL_RUN_LEN   = 4 * N_SLOTS + 6;
  // scan plus worst-case write run, rounded up
  localparam int DRAIN_CYCLES   = 64;
  // long output stall used to back the block up
  localparam int HOLD_CYCLES    = 300;
  // quiet cycles allowed before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // channel instances and their drivers
  pftp_in_if  in_if ();
  pftp_out_if out_if ();

  logic                          tx_valid = 1'b0;
  logic                          tx_mode  = 1'b0;
  logic [pftp_pkg::SLOT_W-1:0]   tx_slot  = '0;
  logic [pftp_pkg::PID_W-1:0]    tx_pid   = '0;
  logic                          tx_on    = 1'b0;
  logic                          rx_ready = 1'b0;

  assign in_if.valid  = tx_valid;
  assign in_if.mode   = tx_mode;
  assign in_if.slot   = tx_slot;
  assign in_if.pid    = tx_pid;
  assign in_if.on     = tx_on;
  assign out_if.ready = rx_ready;

  pid_filter_table_programmer_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predictor state: slot store and filtering flag as the block holds them
  logic [pftp_pkg::PID_W-1:0] slot_store [N_SLOTS];
  logic                       filter_on;

  // write items still owed by the block, oldest first
  pftp_pkg::out_word_t table_writes_due [$];

  // idling knobs and the hold-off request
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req    = 0;
  int hold_ack    = 0;
  int hold_left   = 0;

  // bookkeeping
  int mismatches      = 0;
  int items_sent      = 0;
  int writes_checked  = 0;
  int error_items     = 0;
  int forced_off_runs = 0;
  int full_runs       = 0;
  int quiet_cycles    = 0;

  // -------------------------------------------------------------------------
  // prediction
  // -------------------------------------------------------------------------

  // one entry write is a flagged value word followed by a zero word
  task automatic add_entry(input logic [7:0] typ_code, input int unsigned entry,
                           input logic [pftp_pkg::PID_W-1:0] value, input logic fin);
    logic [pftp_pkg::WORD_W-1:0] idx;
    pftp_pkg::out_word_t         w;
    idx           = {typ_code, 8'h00} | 16'(entry * 4);
    w.write_value = value | pftp_pkg::PID_FLAG;
    w.write_index = idx;
    w.status      = 1'b0;
    w.last        = 1'b0;
    table_writes_due.push_back(w);
    w.write_value = '0;
    w.last        = fin;
    table_writes_due.push_back(w);
  endtask

  // update the slot store and queue the whole programming sequence
  task automatic predict_table_writes(input logic mode,
                                      input logic [pftp_pkg::SLOT_W-1:0] slot,
                                      input logic [pftp_pkg::PID_W-1:0] pid,
                                      input logic on);
    logic                enable;
    logic                failed;
    int unsigned         entry;
    int                  start_len;
    pftp_pkg::out_word_t err_w;
    start_len = table_writes_due.size();
    failed    = 1'b0;

    if (!mode) begin
      if (int'(slot) < N_SLOTS) slot_store[slot] = on ? pid : '0;
    end else begin
      filter_on = on;
    end

    // a slot holding the force-off pid vetoes filtering
    enable = filter_on;
    foreach (slot_store[i]) if (slot_store[i] == pftp_pkg::FORCE_OFF_PID) enable = 1'b0;
    if (filter_on && !enable) forced_off_runs++;

    // clear the table and park the control register
    add_entry(pftp_pkg::TYPE_TABLE, 1, {15'd0, enable}, 1'b0);
    for (int i = 0; i < N_SLOTS; i++) add_entry(pftp_pkg::TYPE_TABLE, i + 2, '0, 1'b0);
    add_entry(pftp_pkg::TYPE_CTRL, 0, '0, 1'b0);

    // pack nonzero slots into consecutive entries, stop on an oversized pid
    if (enable) begin
      entry = 2;
      foreach (slot_store[i]) begin
        if (!failed && slot_store[i] != '0) begin
          if (slot_store[i] >= pftp_pkg::PID_FLAG) begin
            err_w.write_value = '0;
            err_w.write_index = '0;
            err_w.status      = 1'b1;
            err_w.last        = 1'b1;
            table_writes_due.push_back(err_w);
            failed = 1'b1;
            error_items++;
          end else begin
            add_entry(pftp_pkg::TYPE_TABLE, entry, slot_store[i], 1'b0);
            entry++;
          end
        end
      end
    end

    if (!failed) add_entry(pftp_pkg::TYPE_CTRL, 0, pftp_pkg::CTRL_WORD, 1'b1);
    if (table_writes_due.size() - start_len == FULL_RUN_LEN) full_runs++;
  endtask

  // -------------------------------------------------------------------------
  // sender
  // -------------------------------------------------------------------------

  // called and returning in the time step of a rising edge; the payload is
  // predicted at the falling edge just before the accepting edge
  task automatic send_update(input logic mode, input logic [pftp_pkg::SLOT_W-1:0] slot,
                             input logic [pftp_pkg::PID_W-1:0] pid, input logic on);
    while ($urandom_range(99) < tx_idle_pct) begin
      tx_valid <= 1'b0;
      @(posedge clk);
    end
    tx_valid <= 1'b1;
    tx_mode  <= mode;
    tx_slot  <= slot;
    tx_pid   <= pid;
    tx_on    <= on;
    do @(negedge clk); while (in_if.ready !== 1'b1);
    predict_table_writes(mode, slot, pid, on);
    @(posedge clk);
    items_sent++;
  endtask

  // sender stops and waits until every owed write item has come back
  task automatic wait_drained();
    tx_valid <= 1'b0;
    while (table_writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // receiver: random stalls plus an occasional long hold-off
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      rx_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rx_ready  <= 1'b0;
    end else begin
      rx_ready  <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // checker: handshake seen at the falling edge is taken at the next rise
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    pftp_pkg::out_word_t got;
    pftp_pkg::out_word_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.write_value = out_if.write_value;
      got.write_index = out_if.write_index;
      got.status      = out_if.status;
      got.last        = out_if.last;
      if (table_writes_due.size() == 0) begin
        $display("%0t: unexpected write item value %h index %h status %b last %b",
                 $time, got.write_value, got.write_index, got.status, got.last);
        mismatches++;
      end else begin
        want = table_writes_due.pop_front();
        writes_checked++;
        if (got.write_value !== want.write_value || got.write_index !== want.write_index ||
            got.status !== want.status || got.last !== want.last) begin
          $display("%0t: write mismatch, expected value %h index %h status %b last %b",
                   $time, want.write_value, want.write_index, want.status, want.last);
          $display("%0t:                 actual   value %h index %h status %b last %b",
                   $time, got.write_value, got.write_index, got.status, got.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(negedge clk) begin
    if (!rst_n || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------

  // filtering off and on with an empty table, mode 1 ignores slot and pid
  task automatic test_enable_switch();
    send_update(1'b1, 3'd0, 16'h0000, 1'b0);
    send_update(1'b1, 3'd5, 16'habcd, 1'b1);
    send_update(1'b1, 3'd2, 16'h8000, 1'b0);
    send_update(1'b1, 3'd7, 16'hffff, 1'b1);
    wait_drained();
  endtask

  // pids at the field extremes, zero slots skipped, on low stores zero
  task automatic test_slot_packing();
    send_update(1'b0, 3'd0, 16'h0001, 1'b1);
    send_update(1'b0, 3'd7, 16'h7fff, 1'b1);
    send_update(1'b0, 3'd3, 16'h5555, 1'b1);
    send_update(1'b0, 3'd4, 16'h2aaa, 1'b1);
    send_update(1'b0, 3'd1, 16'h1fff, 1'b1);
    send_update(1'b0, 3'd2, 16'h2001, 1'b1);
    send_update(1'b0, 3'd5, 16'h0000, 1'b1);
    send_update(1'b0, 3'd6, 16'h1234, 1'b0);
    // every slot filled: longest sequence
    send_update(1'b0, 3'd5, 16'h0f0f, 1'b1);
    send_update(1'b0, 3'd6, 16'h00ff, 1'b1);
    wait_drained();
  endtask

  // the force-off pid in any slot disables packing, even over a bad pid
  task automatic test_force_off_pid();
    send_update(1'b0, 3'd6, pftp_pkg::FORCE_OFF_PID, 1'b1);
    send_update(1'b1, 3'd0, 16'h0000, 1'b1);
    send_update(1'b0, 3'd0, 16'h8001, 1'b1);
    send_update(1'b0, 3'd6, 16'h4000, 1'b0);
    send_update(1'b0, 3'd0, pftp_pkg::FORCE_OFF_PID, 1'b1);
    send_update(1'b0, 3'd0, 16'h0002, 1'b1);
    wait_drained();
  endtask

  // an oversized pid ends the run with an error item, slot keeps it
  task automatic test_pid_too_large();
    send_update(1'b0, 3'd6, 16'hffff, 1'b1);
    send_update(1'b0, 3'd7, 16'h8000, 1'b1);
    send_update(1'b0, 3'd6, 16'h0000, 1'b1);
    send_update(1'b0, 3'd7, 16'h7ffe, 1'b1);
    wait_drained();
  endtask

  // receiver holds off long while the sender keeps offering updates
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_idle_pct <= 0;
    hold_req    <= hold_req + 1;
    for (int i = 0; i < 6; i++)
      send_update(1'b0, 3'($urandom_range(7)), 16'($urandom_range(16'h7fff)), 1'b1);
    wait_drained();
  endtask

  // random updates: mostly valid slot writes, some switches, rare bad pids
  task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
    logic                        mode;
    logic [pftp_pkg::SLOT_W-1:0] slot;
    logic [pftp_pkg::PID_W-1:0]  pid;
    logic                        on;
    int                          pick;
    tx_idle_pct  = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (count) begin
      mode = ($urandom_range(99) < 15);
      slot = 3'($urandom_range(N_SLOTS - 1));
      on   = mode ? ($urandom_range(99) < 80) : ($urandom_range(99) >= 20);
      pick = $urandom_range(99);
      if (pick < 3)       pid = pftp_pkg::FORCE_OFF_PID;
      else if (pick < 7)  pid = pftp_pkg::PID_FLAG | 16'($urandom_range(16'h7fff));
      else if (pick < 20) pid = 16'($urandom_range(15));
      else                pid = 16'($urandom_range(16'h7fff));
      send_update(mode, slot, pid, on);
    end
    wait_drained();
  endtask

  // -------------------------------------------------------------------------
  // sequence of the run
  // -------------------------------------------------------------------------
  initial begin
    foreach (slot_store[i]) slot_store[i] = '0;
    filter_on = 1'b0;

    // reset once, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_enable_switch();
    test_slot_packing();
    test_force_off_pid();
    test_pid_too_large();
    test_output_backpressure();
    test_random_traffic(60, 36, 67);
    test_random_traffic(60, 67, 36);
    test_random_traffic(40, 0, 0);

    $display("summary: %0d updates sent, %0d write items checked, %0d error items",
             items_sent, writes_checked, error_items);
    $display("summary: %0d runs forced off by the 8192 pid, %0d full-table runs",
             forced_off_runs, full_runs);
    if (mismatches == 0 && table_writes_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d write items never arrived",
               mismatches, table_writes_due.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pftp_pkg.sv
rtl/core/pftp_if.sv
rtl/core/pftp_word_unit.sv
rtl/core/pftp_seq.sv
rtl/core/pid_filter_table_programmer_core.sv
sim/testbench.sv
